// ===== hw/rtl/scip_pkg.sv =====
// Shared constants and types for the shutter curve interpolator.
`timescale 1ns / 1ps
`default_nettype none

package scip_pkg;

   localparam int DATA_W         = 16;
   localparam int CNT_W          = 5;
   localparam int PIDX_W         = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int MAX_POINTS_DEF = 16;
   localparam int DIV_STEPS      = DATA_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   typedef logic [DATA_W-1:0] data_type;

   localparam data_type WEIGHT_ONE  = data_type'(16'h0100);
   localparam data_type WEIGHT_ZERO = '0;

   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_END    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam data_type  SPAN_START_RST  = '0;
   localparam data_type  SPAN_END_RST    = '1;
   localparam logic [CNT_W-1:0] POINT_COUNT_RST = 5'd2;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SRCH     = 9'b000000010,
      ST_FETCH_LO = 9'b000000100,
      ST_FETCH_HI = 9'b000001000,
      ST_CAPT     = 9'b000010000,
      ST_MUL      = 9'b000100000,
      ST_PREP     = 9'b001000000,
      ST_DIV      = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/shutter_curve_interpolator_core.sv =====
// Piecewise-linear shutter weight curve: point table, search, interpolation.
// Load: accepted while idle, no result beat.
// Query outside the span or on a zero-length span: goes straight to ST_DONE, result registered once the output is free.
// Interpolated query: the search reads
// one table entry per cycle through a single read port and the divider retires one bit per cycle.
// One query at a time. Synchronous reset restores the state, valid flags and CSRs; the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module shutter_curve_interpolator_core #(
   parameter int MAX_POINTS = scip_pkg::MAX_POINTS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_type,
   input  wire  [scip_pkg::PIDX_W-1:0]          req_point_index,
   input  wire  [scip_pkg::DATA_W-1:0]          req_point_time,
   input  wire  [scip_pkg::DATA_W-1:0]          req_point_weight,
   input  wire  [scip_pkg::DATA_W-1:0]          req_query_time,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [scip_pkg::DATA_W-1:0]          rsp_weight,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [scip_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [scip_pkg::DATA_W-1:0]          csr_data
);
   import scip_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int N_W   = $clog2(MAX_POINTS + 1);
   localparam int CW    = (N_W > CNT_W) ? N_W : CNT_W;

   // table
   data_type times_mem   [MAX_POINTS];
   data_type weights_mem [MAX_POINTS];
   data_type rd_time_ff, rd_weight_ff;
   logic [IDX_W-1:0] rd_addr;

   state_type state_ff, state_in;
   data_type span_start_ff, span_end_ff;
   logic [CNT_W-1:0] point_count_ff;

   logic [IDX_W-1:0] issue_ff, issue_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0] u_ff, u_in;
   data_type q_ff, q_in;
   data_type t0_ff, t0_in, w0_ff, w0_in;
   data_type den_ff, den_in, dist_ff, dist_in, diff_ff, diff_in;
   logic up_ff, up_in;
   logic [2*DATA_W-1:0] prod_ff, prod_in;
   data_type rem_ff, rem_in, num_lo_ff, num_lo_in, quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   data_type result_ff, result_in;
   logic rsp_valid_ff, rsp_valid_in;
   data_type rsp_weight_ff, rsp_weight_in;

   logic req_accept, load_en, out_free;
   logic [CW-1:0] cnt_ext, n_cl;
   logic [IDX_W-1:0] last_idx;
   logic [DATA_W:0] trial, rem_sub;
   logic [2*DATA_W:0] num;
   data_type t1;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_en    = req_accept && (req_type == REQ_LOAD)
                       && (int'(req_point_index) < MAX_POINTS);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign cnt_ext  = CW'(point_count_ff);
   assign n_cl     = (cnt_ext < CW'(2)) ? CW'(2)
                   : (cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext;
   assign last_idx = IDX_W'(n_cl - CW'(1));

   assign t1      = rd_time_ff;
   assign trial   = {rem_ff, num_lo_ff[DATA_W-1]};
   assign rem_sub = trial - {1'b0, den_ff};
   assign num     = {1'b0, prod_ff}
                  + (up_ff ? '0 : (2*DATA_W+1)'(den_ff - data_type'(1)));

   always_ff @(posedge clock) begin
      if (load_en) begin
         times_mem[IDX_W'(req_point_index)]   <= req_point_time;
         weights_mem[IDX_W'(req_point_index)] <= req_point_weight;
      end
      rd_time_ff   <= times_mem[rd_addr];
      rd_weight_ff <= weights_mem[rd_addr];
   end

   always_comb begin
      unique case (state_ff)
         ST_FETCH_LO: rd_addr = u_ff - IDX_W'(1);
         ST_FETCH_HI: rd_addr = u_ff;
         default:     rd_addr = issue_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = chk_valid_ff;
      u_in         = u_ff;
      q_in         = q_ff;
      t0_in        = t0_ff;
      w0_in        = w0_ff;
      den_in       = den_ff;
      dist_in      = dist_ff;
      diff_in      = diff_ff;
      up_in        = up_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      num_lo_in    = num_lo_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_weight_in = rsp_weight_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_type == REQ_QUERY) begin
               q_in = req_query_time;
               if (req_query_time < span_start_ff || req_query_time > span_end_ff) begin
                  result_in = WEIGHT_ZERO;
                  state_in  = ST_DONE;
               end else if (span_start_ff == span_end_ff) begin
                  result_in = WEIGHT_ONE;
                  state_in  = ST_DONE;
               end else begin
                  issue_in     = '0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            issue_in     = issue_ff + IDX_W'(1);
            chk_idx_in   = issue_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff && (rd_time_ff > q_ff || chk_idx_ff == last_idx)) begin
               u_in     = (chk_idx_ff == '0) ? IDX_W'(1) : chk_idx_ff;
               state_in = ST_FETCH_LO;
            end
         end
         ST_FETCH_LO: state_in = ST_FETCH_HI;
         ST_FETCH_HI: begin
            t0_in    = rd_time_ff;
            w0_in    = rd_weight_ff;
            state_in = ST_CAPT;
         end
         ST_CAPT: begin
            den_in  = t1 - t0_ff;
            up_in   = (rd_weight_ff >= w0_ff);
            diff_in = (rd_weight_ff >= w0_ff) ? rd_weight_ff - w0_ff : w0_ff - rd_weight_ff;
            if (q_ff <= t0_ff)   dist_in = '0;
            else if (q_ff >= t1) dist_in = t1 - t0_ff;
            else                 dist_in = q_ff - t0_ff;
            if (t1 <= t0_ff) begin
               result_in = w0_ff;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = diff_ff * dist_ff;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            rem_in     = num[2*DATA_W-1:DATA_W];
            num_lo_in  = num[DATA_W-1:0];
            quo_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            num_lo_in  = num_lo_ff << 1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (!rem_sub[DATA_W]) begin
               rem_in = rem_sub[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               result_in = up_ff ? w0_ff + quo_in : w0_ff - quo_in;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = result_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         chk_valid_ff   <= 1'b0;
         span_start_ff  <= SPAN_START_RST;
         span_end_ff    <= SPAN_END_RST;
         point_count_ff <= POINT_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_valid_ff <= chk_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SPAN_START:  span_start_ff  <= csr_data;
               CSR_SPAN_END:    span_end_ff    <= csr_data;
               CSR_POINT_COUNT: point_count_ff <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      u_ff          <= u_in;
      q_ff          <= q_in;
      t0_ff         <= t0_in;
      w0_ff         <= w0_in;
      den_ff        <= den_in;
      dist_ff       <= dist_in;
      diff_ff       <= diff_in;
      up_ff         <= up_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      num_lo_ff     <= num_lo_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      result_ff     <= result_in;
      rsp_weight_ff <= rsp_weight_in;
   end

endmodule

`default_nettype wire
